// File: sv/fcmp_pkg.sv
`default_nettype none
package fcmp_pkg;
    localparam logic [3:0] OP_MIN   = 4'd0;
    localparam logic [3:0] OP_MAX   = 4'd1;
    localparam logic [3:0] OP_SGNJ  = 4'd2;
    localparam logic [3:0] OP_SGNJN = 4'd3;
    localparam logic [3:0] OP_SGNJX = 4'd4;
    localparam logic [3:0] OP_EQ    = 4'd5;
    localparam logic [3:0] OP_LT    = 4'd6;
    localparam logic [3:0] OP_LE    = 4'd7;
    localparam logic [3:0] OP_CLASS = 4'd8;

    localparam logic [31:0] MAG_MASK  = 32'h7fff_ffff;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] CANON_NAN = 32'h7fc0_0000;

    // operand facts found in the first stage
    typedef struct packed {
        logic nan;
        logic snan;
        logic zero;
        logic [9:0] cls;
    } fp_info_t;
endpackage
`default_nettype wire

// File: sv/fp32_compare_minmax_sign_unit.sv
`default_nettype none
// Single-precision compare, min/max, sign-injection and classify unit.
// Input channel: in_valid/in_ready with op, operand_a, operand_b.
// Output channel: out_valid/out_ready with result_bits, invalid_flag.
// An input word is taken when valid and ready are both high; one result
// word comes out per input word, in order.
// Three register stages (decode, compare, result select); out_valid is the
// stage-3 valid bit, so an accepted word passes the stage-1, stage-2 and
// stage-3 registers in order before it can be read.
// Throughput: one word per cycle; the pipeline advances whenever its
// last stage is empty or being read.
// When the receiver stalls with a result word waiting, all stages hold and
// in_ready drops at once; nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears all stage valid bits; no
// clearing pass is needed.
module fp32_compare_minmax_sign_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [3:0]  op,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result_bits,
    output logic             invalid_flag
);
    import fcmp_pkg::*;

    logic advance;
    assign advance  = ~out_valid | out_ready;
    assign in_ready = advance;

    // stage 1: capture operands and classify
    fp_info_t ia, ib;
    fcmp_decode u_dec_a (.x(operand_a), .info(ia));
    fcmp_decode u_dec_b (.x(operand_b), .info(ib));

    logic        v1_reg;
    logic [3:0]  op1_reg;
    logic [31:0] a1_reg, b1_reg;
    fp_info_t    ia1_reg, ib1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (advance) v1_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op1_reg <= op;
            a1_reg  <= operand_a;
            b1_reg  <= operand_b;
            ia1_reg <= ia;
            ib1_reg <= ib;
        end
    end

    // stage 2: order keys and compare
    logic [31:0] ka, kb;
    logic lt_ab, lt_ba, both_zero, eq_bits;
    always_comb
    begin
        ka = a1_reg[31] ? ~a1_reg : (a1_reg | SIGN_MASK);
        kb = b1_reg[31] ? ~b1_reg : (b1_reg | SIGN_MASK);
        both_zero = ia1_reg.zero & ib1_reg.zero;
        lt_ab = ~both_zero & (ka < kb);
        lt_ba = ~both_zero & (kb < ka);
        eq_bits = (a1_reg == b1_reg) | both_zero;
    end

    logic        v2_reg;
    logic [3:0]  op2_reg;
    logic [31:0] a2_reg, b2_reg;
    fp_info_t    ia2_reg, ib2_reg;
    logic        lt_ab2_reg, lt_ba2_reg, eq2_reg, bz2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else if (advance) v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            op2_reg    <= op1_reg;
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            ia2_reg    <= ia1_reg;
            ib2_reg    <= ib1_reg;
            lt_ab2_reg <= lt_ab;
            lt_ba2_reg <= lt_ba;
            eq2_reg    <= eq_bits;
            bz2_reg    <= both_zero;
        end
    end

    // stage 3: select result and flag
    logic [31:0] res_next;
    logic        inv_next;
    logic        anyn, sn;
    always_comb
    begin
        anyn = ia2_reg.nan | ib2_reg.nan;
        sn   = ia2_reg.snan | ib2_reg.snan;
        res_next = 32'd0;
        inv_next = 1'b0;
        case (op2_reg) inside
            OP_MIN, OP_MAX:
            begin
                inv_next = sn;
                if (ia2_reg.nan & ib2_reg.nan) res_next = CANON_NAN;
                else if (ia2_reg.nan)          res_next = b2_reg;
                else if (ib2_reg.nan)          res_next = a2_reg;
                else if (bz2_reg)
                begin
                    if (op2_reg == OP_MIN) res_next = a2_reg[31] ? a2_reg : b2_reg;
                    else                   res_next = b2_reg[31] ? a2_reg : b2_reg;
                end
                else if (op2_reg == OP_MIN) res_next = lt_ba2_reg ? b2_reg : a2_reg;
                else                        res_next = lt_ab2_reg ? b2_reg : a2_reg;
            end
            OP_SGNJ:  res_next = (a2_reg & MAG_MASK) | (b2_reg & SIGN_MASK);
            OP_SGNJN: res_next = (a2_reg & MAG_MASK) | (~b2_reg & SIGN_MASK);
            OP_SGNJX: res_next = (a2_reg & MAG_MASK) | ((a2_reg ^ b2_reg) & SIGN_MASK);
            OP_EQ:
            begin
                inv_next = sn;
                res_next = {31'd0, ~anyn & eq2_reg};
            end
            OP_LT:
            begin
                inv_next = anyn;
                res_next = {31'd0, ~anyn & lt_ab2_reg};
            end
            OP_LE:
            begin
                inv_next = anyn;
                res_next = {31'd0, ~anyn & ~lt_ba2_reg};
            end
            OP_CLASS: res_next = {22'd0, ia2_reg.cls};
            default:
            begin
                res_next = 32'd0;
                inv_next = 1'b0;
            end
        endcase
    end

    logic        v3_reg;
    logic [31:0] res_reg;
    logic        inv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (advance) v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
            inv_reg <= inv_next;
        end
    end

    assign out_valid    = v3_reg;
    assign result_bits  = res_reg;
    assign invalid_flag = inv_reg;
endmodule
`default_nettype wire

// File: sv/fcmp_decode.sv
`default_nettype none
module fcmp_decode (
    input  wire logic [31:0]      x,
    output fcmp_pkg::fp_info_t    info
);
    import fcmp_pkg::*;
    logic neg;
    logic e_ones;
    logic e_zero;
    logic f_zero;

    // classify one operand from its fields
    always_comb
    begin
        neg    = x[31];
        e_ones = &x[30:23];
        e_zero = ~|x[30:23];
        f_zero = ~|x[22:0];
        info.nan  = e_ones & ~f_zero;
        info.snan = e_ones & ~f_zero & ~x[22];
        info.zero = e_zero & f_zero;
        info.cls  = 10'd0;
        if (e_ones)
        begin
            if (f_zero) info.cls[neg ? 0 : 7] = 1'b1;
            else        info.cls[x[22] ? 9 : 8] = 1'b1;
        end
        else if (e_zero)
        begin
            if (f_zero) info.cls[neg ? 3 : 4] = 1'b1;
            else        info.cls[neg ? 2 : 5] = 1'b1;
        end
        else
        begin
            info.cls[neg ? 1 : 6] = 1'b1;
        end
    end
endmodule
`default_nettype wire
